@@ rtl/assert_macros.svh @@
// shared assertion macros for the ditherer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on an explicit clock and active-low reset
`define EDD_ASSERT_CK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// concurrent check on the usual clk_i / rst_ni pair
`define EDD_ASSERT(lbl, prop, msg) `EDD_ASSERT_CK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/edd332_pkg.sv @@
package edd332_pkg;

  // configuration port
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;

  localparam int IMAGE_WIDTH_RESET  = 640;
  localparam int IMAGE_HEIGHT_RESET = 480;

  typedef logic [7:0] chan_t;
  typedef logic signed [7:0] err_t;
  // one signed error per channel: [0] red, [1] green, [2] blue
  typedef logic [2:0][7:0] err_vec_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] color_index;
    logic       end_of_frame;
  } result_t;

  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_col;
    logic last_row;
  } pos_t;

  typedef struct packed {
    pixel_t pix;
    pos_t   pos;
  } stage_t;

  // line buffer updates of one pixel: column to the left and own column
  typedef struct packed {
    logic     prev_en;
    logic     cur_en;
    err_vec_t prev_data;
    err_vec_t cur_data;
  } line_wr_t;

  // palette levels of the 3-bit red and green codes
  function automatic logic [7:0] level_rg(logic [2:0] q);
    logic [7:0] lev;
    unique case (q)
      3'd0: lev = 8'd0;
      3'd1: lev = 8'd36;
      3'd2: lev = 8'd73;
      3'd3: lev = 8'd109;
      3'd4: lev = 8'd146;
      3'd5: lev = 8'd182;
      3'd6: lev = 8'd219;
      default: lev = 8'd255;
    endcase
    return lev;
  endfunction

  // palette levels of the 2-bit blue code
  function automatic logic [7:0] level_b(logic [1:0] q);
    logic [7:0] lev;
    unique case (q)
      2'd0: lev = 8'd0;
      2'd1: lev = 8'd85;
      2'd2: lev = 8'd170;
      default: lev = 8'd255;
    endcase
    return lev;
  endfunction

  // divide by 16, truncating toward zero
  function automatic err_t div16(logic signed [10:0] t);
    logic signed [10:0] adj;
    adj = t + (t[10] ? 11'sd15 : 11'sd0);
    return err_t'(adj >>> 4);
  endfunction

  function automatic chan_t clamp8(logic signed [10:0] s);
    chan_t v;
    if (s[10]) begin
      v = 8'd0;
    end else if (s > 11'sd255) begin
      v = 8'hFF;
    end else begin
      v = s[7:0];
    end
    return v;
  endfunction

endpackage

@@ rtl/edd332_stream_if.sv @@
interface edd332_pixel_if;
  logic                 valid;
  logic                 ready;
  edd332_pkg::pixel_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface edd332_index_if;
  logic                 valid;
  logic                 ready;
  edd332_pkg::result_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/error_diffusion_dither_rgb332_unit.sv @@
// channel   dir  handshake     word
// pix_i     in   valid/ready   red, green, blue (8 bits each)
// idx_o     out  valid/ready   color_index (RRRGGGBB), end_of_frame
// cfg       in   cfg_we_i      cfg_idx_i selects image_width / image_height
//
// one pixel per clock sustained while idx_o keeps taking words; a pixel's index
// passes stage a, then out_q (line buffer read as it is taken, then the error datapath into idx_o)
// the rate is set by the right-error carry loop, closed through the carry_q register
// no clearing pass after reset: the first row of each frame ignores the line buffer
// a stalled idx_o holds one word and the one behind it, then drops pix_i.ready
`include "assert_macros.svh"

module error_diffusion_dither_rgb332_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [edd332_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [edd332_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  edd332_pixel_if.sink                        pix_i,
  edd332_index_if.source                      idx_o
);
  import edd332_pkg::*;

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  // even columns live in bank 0, odd ones in bank 1
  localparam int BANK_AW = (COL_W > 1) ? COL_W - 1 : 1;
  localparam int RST_W   = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET;
  localparam logic [COL_W-1:0] RST_LASTCOL = COL_W'(RST_W - 1);
  localparam logic [HEIGHT_REG_W-1:0] RST_LASTROW = HEIGHT_REG_W'(IMAGE_HEIGHT_RESET - 1);

  // frame geometry, kept as last column and last row indexes
  logic [COL_W-1:0]        lastcol_q, lastcol_d;
  logic [HEIGHT_REG_W-1:0] lastrow_q, lastrow_d;
  logic                    restart;

  // raster position of the next pixel taken
  logic [COL_W-1:0]        col_q, col_d;
  logic [HEIGHT_REG_W-1:0] row_q, row_d;

  // stage a: pixel waiting for its line buffer entry
  stage_t           a_q, a_d;
  logic [COL_W-1:0] a_col_q;
  logic             a_vld_q, a_vld_d;

  // output word
  result_t out_q;
  logic    out_vld_q, out_vld_d;

  logic    pix_fire;
  logic    fire_b;
  pos_t    pos;
  result_t res;
  line_wr_t wr;
  err_vec_t line_data;

  logic [COL_W-1:0]   prev_col;
  logic [BANK_AW-1:0] bank_raddr;
  logic               bank_we    [2];
  logic [BANK_AW-1:0] bank_waddr [2];
  err_vec_t           bank_wdata [2];
  err_vec_t           bank_rdata [2];

  // config decode, width and height clamped here once
  always_comb begin
    int unsigned wv;
    int unsigned hv;
    wv        = 32'(cfg_wdata_i[WIDTH_REG_W-1:0]);
    hv        = 32'(cfg_wdata_i[HEIGHT_REG_W-1:0]);
    lastcol_d = lastcol_q;
    lastrow_d = lastrow_q;
    restart   = 1'b0;
    if (wv == 0) wv = 1;
    if (wv > MAX_WIDTH) wv = MAX_WIDTH;
    if (hv == 0) hv = 1;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH: begin
          lastcol_d = COL_W'(wv - 1);
          restart   = 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          lastrow_d = HEIGHT_REG_W'(hv - 1);
          restart   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // handshake: stage a moves on when the output word can take its result
  assign fire_b      = a_vld_q && (!out_vld_q || idx_o.ready);
  assign pix_i.ready = !a_vld_q || fire_b;
  assign pix_fire    = pix_i.valid && pix_i.ready;

  assign pos.first_row = (row_q == '0);
  assign pos.first_col = (col_q == '0);
  assign pos.last_col  = (col_q == lastcol_q);
  assign pos.last_row  = (row_q == lastrow_q);

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    a_d       = a_q;
    a_vld_d   = a_vld_q;
    out_vld_d = out_vld_q;
    if (fire_b) begin
      a_vld_d   = 1'b0;
      out_vld_d = 1'b1;
    end else if (idx_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (pix_fire) begin
      a_d.pix = pix_i.data;
      a_d.pos = pos;
      a_vld_d = 1'b1;
      if (pos.last_col) begin
        col_d = '0;
        row_d = pos.last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lastcol_q <= RST_LASTCOL;
      lastrow_q <= RST_LASTROW;
      col_q     <= '0;
      row_q     <= '0;
      a_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      lastcol_q <= lastcol_d;
      lastrow_q <= lastrow_d;
      col_q     <= col_d;
      row_q     <= row_d;
      a_vld_q   <= a_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    if (pix_fire) begin
      a_col_q <= col_q;
    end
    if (fire_b) begin
      out_q <= res;
    end
  end

  assign idx_o.valid = out_vld_q;
  assign idx_o.data  = out_q;

  // line buffer: read the column of the pixel being taken, write behind it
  assign bank_raddr = BANK_AW'(col_q >> 1);
  assign prev_col   = COL_W'(a_col_q - 1'b1);
  assign line_data  = a_col_q[0] ? bank_rdata[1] : bank_rdata[0];

  // the two writes of a row end always fall in different banks
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      bank_we[b]    = 1'b0;
      bank_waddr[b] = BANK_AW'(prev_col >> 1);
      bank_wdata[b] = wr.prev_data;
      if (wr.prev_en && (prev_col[0] == 1'(b))) begin
        bank_we[b] = 1'b1;
      end else if (wr.cur_en && (a_col_q[0] == 1'(b))) begin
        bank_we[b]    = 1'b1;
        bank_waddr[b] = BANK_AW'(a_col_q >> 1);
        bank_wdata[b] = wr.cur_data;
      end
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    edd332_line_bank #(
      .AW (BANK_AW)
    ) u_bank (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .we_i    (bank_we[b]),
      .waddr_i (bank_waddr[b]),
      .wdata_i (bank_wdata[b]),
      .re_i    (pix_fire),
      .raddr_i (bank_raddr),
      .rdata_o (bank_rdata[b])
    );
  end

  // error datapath and carry / pending state
  edd332_diffuse u_diffuse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (restart),
    .fire_i  (fire_b),
    .ctl_i   (a_q),
    .line_i  (line_data),
    .res_o   (res),
    .wr_o    (wr)
  );

  `EDD_ASSERT(a_stage_hold, a_vld_q && !fire_b |=> a_vld_q && $stable(a_q), "stage a overwritten while waiting")
  `EDD_ASSERT(a_col_in_row, col_q <= lastcol_q, "column counter past last column")
  `EDD_ASSERT(a_frame_wrap, pix_fire && pos.last_col && pos.last_row |=> (col_q == '0) && (row_q == '0), "counters did not wrap at end of frame")

endmodule

@@ rtl/edd332_line_bank.sv @@
module edd332_line_bank #(
  parameter int AW = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  edd332_pkg::err_vec_t wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output edd332_pkg::err_vec_t rdata_o
);
  import edd332_pkg::*;

  localparam int DEPTH = 1 << AW;

  err_vec_t mem_q [DEPTH];
  err_vec_t rd_q;
  err_vec_t byp_data_q;
  logic     byp_vld_q;

  // read-first array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q       <= mem_q[raddr_i];
      byp_data_q <= wdata_i;
    end
  end

  // same-cycle write to the address being read wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_vld_q <= 1'b0;
    end else if (re_i) begin
      byp_vld_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_vld_q ? byp_data_q : rd_q;

endmodule

@@ rtl/edd332_diffuse.sv @@
`include "assert_macros.svh"

module edd332_diffuse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic                 fire_i,
  input  edd332_pkg::stage_t   ctl_i,
  input  edd332_pkg::err_vec_t line_i,
  output edd332_pkg::result_t  res_o,
  output edd332_pkg::line_wr_t wr_o
);
  import edd332_pkg::*;

  err_vec_t carry_q, carry_d;
  err_vec_t p0_q, p0_d;
  err_vec_t p1_q, p1_d;

  logic [2:0][7:0] chan;
  logic [2:0][7:0] val;
  err_t e7 [3];
  err_t e5 [3];
  err_t e3 [3];
  err_t e1 [3];

  always_comb begin
    logic signed [10:0] sum;
    logic signed [10:0] err;
    logic signed [10:0] line_term;
    logic signed [10:0] carry_term;
    logic [7:0]         lev;
    chan[0] = ctl_i.pix.red;
    chan[1] = ctl_i.pix.green;
    chan[2] = ctl_i.pix.blue;
    for (int c = 0; c < 3; c++) begin
      line_term  = ctl_i.pos.first_row ? 11'sd0 : 11'($signed(line_i[c]));
      carry_term = ctl_i.pos.first_col ? 11'sd0 : 11'($signed(carry_q[c]));
      sum        = $signed({3'b000, chan[c]}) + line_term + carry_term;
      val[c]     = clamp8(sum);
      lev        = (c == 2) ? level_b(val[c][7:6]) : level_rg(val[c][7:5]);
      err        = $signed({3'b000, val[c]}) - $signed({3'b000, lev});
      e7[c]      = div16(err * 11'sd7);
      e5[c]      = div16(err * 11'sd5);
      e3[c]      = div16(err * 11'sd3);
      e1[c]      = div16(err);
    end
  end

  assign res_o.color_index  = {val[0][7:5], val[1][7:5], val[2][7:6]};
  assign res_o.end_of_frame = ctl_i.pos.last_col && ctl_i.pos.last_row;

  always_comb begin
    carry_d      = carry_q;
    p0_d         = p0_q;
    p1_d         = p1_q;
    wr_o.prev_en = 1'b0;
    wr_o.cur_en  = 1'b0;
    for (int c = 0; c < 3; c++) begin
      wr_o.prev_data[c] = 8'($signed(p0_q[c]) + e3[c]);
      wr_o.cur_data[c]  = 8'($signed(p1_q[c]) + e5[c]);
    end
    if (clear_i) begin
      carry_d = '0;
      p0_d    = '0;
      p1_d    = '0;
    end else if (fire_i) begin
      for (int c = 0; c < 3; c++) begin
        carry_d[c] = ctl_i.pos.last_col ? 8'd0 : e7[c];
      end
      if (ctl_i.pos.last_col) begin
        // row ends with nothing pending
        p0_d = '0;
        p1_d = '0;
      end else if (!ctl_i.pos.last_row) begin
        for (int c = 0; c < 3; c++) begin
          p0_d[c] = 8'($signed(p1_q[c]) + e5[c]);
          p1_d[c] = e1[c];
        end
      end
      wr_o.prev_en = !ctl_i.pos.last_row && !ctl_i.pos.first_col;
      wr_o.cur_en  = !ctl_i.pos.last_row && ctl_i.pos.last_col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
      p0_q    <= '0;
      p1_q    <= '0;
    end else begin
      carry_q <= carry_d;
      p0_q    <= p0_d;
      p1_q    <= p1_d;
    end
  end

  `EDD_ASSERT(a_row_start_clean, fire_i && ctl_i.pos.last_col |=> (carry_q == '0) && (p0_q == '0) && (p1_q == '0), "error state not clear at row start")

endmodule

@@ test/tb.sv @@
module tb;
  import edd332_pkg::*;

  // must match the MAX_WIDTH the block is built with
  localparam int MAX_COLS      = 1024;
  // random pixels to send after the directed ones
  localparam int RANDOM_ITEMS  = 1550;
  // cycles with no word moving on either side before giving up
  localparam int STALL_LIMIT   = 1000;
  // drain margin for the two words of output buffer behind the last pixel
  localparam int DRAIN_CYCLES  = 10;
  localparam int MAX_REPORTS   = 10;

  // receiver back-pressure patterns
  typedef enum int {
    RX_ALWAYS,
    RX_PERIODIC,
    RX_RANDOM
  } rx_mode_e;

  // ---------------------------------------------------------------------------
  // dither predictor and index checker
  // ---------------------------------------------------------------------------
  class dither_scoreboard;
    int width_reg;
    int height_reg;
    // next-row error per column, one signed value per channel
    int line_err [MAX_COLS][3];
    // 7/16 shares for the pixel on the right
    int err_carry [3];
    // partial next-row sums: [0] current column, [1] the one after it
    int below_sum [2][3];
    int col_pos;
    int row_pos;
    result_t pending_indices [$];
    int mismatches;
    int pixels_seen;
    int frames_ended;
    int reg_writes;

    function new();
      width_reg  = IMAGE_WIDTH_RESET;
      height_reg = IMAGE_HEIGHT_RESET;
      foreach (line_err[i, c]) line_err[i][c] = 0;
      mismatches   = 0;
      pixels_seen  = 0;
      frames_ended = 0;
      reg_writes   = 0;
      rewind();
    endfunction

    // back to the top-left pixel of a fresh frame
    function void rewind();
      foreach (err_carry[c]) err_carry[c] = 0;
      foreach (below_sum[k, c]) below_sum[k][c] = 0;
      col_pos = 0;
      row_pos = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      reg_writes++;
      if (idx == CFG_IMAGE_WIDTH) begin
        width_reg = int'(value[WIDTH_REG_W-1:0]);
        rewind();
      end else if (idx == CFG_IMAGE_HEIGHT) begin
        height_reg = int'(value[HEIGHT_REG_W-1:0]);
        rewind();
      end
    endfunction

    // evenly spaced palette level of a channel code
    function int tone_level(int chan, int code);
      if (chan == 2) begin
        return (code * 64 * 255 + 96) / 192;
      end
      return (code * 32 * 255 + 112) / 224;
    endfunction

    // quantize one pixel, diffuse its error and queue the expected index word
    function void note_pixel(pixel_t px);
      int eff_w, eff_h, j, v, e, c;
      int raw [3];
      int code [3];
      int err [3];
      bit last_col, last_row;
      result_t word;
      raw[0] = int'(px.red);
      raw[1] = int'(px.green);
      raw[2] = int'(px.blue);
      eff_w = (width_reg == 0) ? 1 : ((width_reg > MAX_COLS) ? MAX_COLS : width_reg);
      eff_h = (height_reg == 0) ? 1 : height_reg;
      j = (col_pos >= eff_w) ? eff_w - 1 : col_pos;
      last_col = (j + 1 >= eff_w);
      last_row = (row_pos + 1 >= eff_h);

      for (c = 0; c < 3; c++) begin
        v = raw[c];
        if (row_pos > 0) v += line_err[j][c];
        if (j > 0) v += err_carry[c];
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        code[c] = (c == 2) ? (v >> 6) : (v >> 5);
        err[c] = v - tone_level(c, code[c]);
      end

      for (c = 0; c < 3; c++) begin
        e = err[c];
        err_carry[c] = last_col ? 0 : (e * 7) / 16;
        if (!last_row) begin
          // down-left share completes the column on the left
          if (j > 0) line_err[j-1][c] = below_sum[0][c] + (e * 3) / 16;
          below_sum[0][c] = below_sum[1][c] + (e * 5) / 16;
          below_sum[1][c] = last_col ? 0 : e / 16;
          if (last_col) begin
            line_err[j][c] = below_sum[0][c];
            below_sum[0][c] = 0;
            below_sum[1][c] = 0;
          end
        end
      end

      word.end_of_frame = 1'b0;
      if (last_col) begin
        col_pos = 0;
        foreach (err_carry[k]) err_carry[k] = 0;
        if (last_row) begin
          row_pos = 0;
          word.end_of_frame = 1'b1;
          foreach (below_sum[k, m]) below_sum[k][m] = 0;
        end else begin
          row_pos = (row_pos + 1) & 16'hFFFF;
        end
      end else begin
        col_pos = j + 1;
      end

      word.color_index = 8'((code[0] << 5) | (code[1] << 2) | code[2]);
      pending_indices.push_back(word);
      pixels_seen++;
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending_indices.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected index word: index %02h eof %0b",
                   got.color_index, got.end_of_frame);
        return;
      end
      want = pending_indices.pop_front();
      if (got.end_of_frame) frames_ended++;
      if (got.color_index !== want.color_index) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("color_index mismatch: expected %02h got %02h",
                   want.color_index, got.color_index);
      end
      if (got.end_of_frame !== want.end_of_frame) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("end_of_frame mismatch: expected %0b got %0b",
                   want.end_of_frame, got.end_of_frame);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset, block
  // ---------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  edd332_pixel_if pix_if ();
  edd332_index_if idx_if ();

  error_diffusion_dither_rgb332_unit #(
    .MAX_WIDTH(MAX_COLS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pix_i      (pix_if),
    .idx_o      (idx_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  dither_scoreboard sb;

  // sender pacing, read only by the driver tasks
  int burst_max = 1;
  int gap_max   = 0;

  // receiver pacing
  rx_mode_e rx_mode   = RX_ALWAYS;
  int       rx_period = 4;
  int       rx_hold   = 1;
  int       rx_tick   = 0;

  int idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // index receiver: ready follows its own pattern, independent of the sender
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_ALWAYS: begin
        idx_if.ready <= 1'b1;
      end
      RX_PERIODIC: begin
        // low while rx_tick modulo rx_period is below rx_hold
        idx_if.ready <= (rx_tick % rx_period) >= rx_hold;
      end
      default: begin
        idx_if.ready <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake monitor and watchdog
  // pixel side first so an index can never overtake its own pixel
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) sb.note_pixel(pix_if.data);
      if (idx_if.valid && idx_if.ready) sb.check_word(idx_if.data);
      if ((pix_if.valid && pix_if.ready) || (idx_if.valid && idx_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no word moved for %0d cycles, %0d indices outstanding",
                 idle_cycles, sb.pending_indices.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly uniform, with extra weight on the rails and on code boundaries
  function automatic chan_t random_channel();
    int pick;
    chan_t val;
    pick = $urandom_range(0, 7);
    case (pick)
      0: val = 8'd0;
      1: val = 8'd255;
      2: val = chan_t'($urandom_range(1, 7) * 32 - 1 + $urandom_range(0, 1));
      default: val = chan_t'($urandom_range(0, 255));
    endcase
    return val;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.red   = random_channel();
    px.green = random_channel();
    px.blue  = random_channel();
    return px;
  endfunction

  // hold one pixel word until it is taken; valid stays high on return
  task automatic push_pixel(pixel_t px);
    pix_if.valid <= 1'b1;
    pix_if.data  <= px;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
  endtask

  // bursts of random length with random gaps in between
  task automatic send_pixels(int count);
    int n, burst_left, gap;
    burst_left = $urandom_range(1, burst_max);
    for (n = 0; n < count; n++) begin
      push_pixel(random_pixel());
      burst_left--;
      if (burst_left == 0 && n != count - 1) begin
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
          pix_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, burst_max);
      end
    end
    pix_if.valid <= 1'b0;
  endtask

  // every pixel yields an index, so an empty queue means the block is idle
  task automatic wait_idle();
    @(posedge clk_i);
    while (sb.pending_indices.size() != 0) @(posedge clk_i);
  endtask

  // write width and/or height on consecutive edges; either write restarts the frame
  task automatic load_frame_size(bit set_w, logic [CFG_DATA_W-1:0] w_val,
                                 bit set_h, logic [CFG_DATA_W-1:0] h_val);
    if (set_w) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IMAGE_WIDTH;
      cfg_wdata_i <= w_val;
      @(posedge clk_i);
      sb.write_reg(CFG_IMAGE_WIDTH, w_val);
    end
    if (set_h) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IMAGE_HEIGHT;
      cfg_wdata_i <= h_val;
      @(posedge clk_i);
      sb.write_reg(CFG_IMAGE_HEIGHT, h_val);
    end
    cfg_we_i <= 1'b0;
  endtask

  // pick sender bursts and a receiver pattern for the next stretch
  task automatic choose_pacing();
    int pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0: begin
        // full rate both ways
        burst_max = 1;
        gap_max   = 0;
        rx_mode   <= RX_ALWAYS;
      end
      1: begin
        burst_max = 16;
        gap_max   = 5;
        rx_mode   <= RX_PERIODIC;
        rx_period <= $urandom_range(2, 12);
        rx_hold   <= 1;
      end
      2: begin
        burst_max = 8;
        gap_max   = 3;
        rx_mode   <= RX_RANDOM;
      end
      default: begin
        // long receiver stalls to fill the output buffer and push back
        burst_max = 4;
        gap_max   = 2;
        rx_mode   <= RX_PERIODIC;
        rx_period <= 12;
        rx_hold   <= $urandom_range(4, 8);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase_no, random_sent, count, w, h;
    bit set_w, set_h;
    logic [CFG_DATA_W-1:0] w_word;

    sb = new();
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_IMAGE_WIDTH;
    cfg_wdata_i  = '0;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset size, first row of a wide frame, rails and code edges
    push_pixel(pixel_t'{8'd0,   8'd0,   8'd0});
    push_pixel(pixel_t'{8'd255, 8'd255, 8'd255});
    push_pixel(pixel_t'{8'd255, 8'd0,   8'd0});
    push_pixel(pixel_t'{8'd0,   8'd255, 8'd0});
    push_pixel(pixel_t'{8'd0,   8'd0,   8'd255});
    push_pixel(pixel_t'{8'd31,  8'd32,  8'd63});
    push_pixel(pixel_t'{8'd224, 8'd223, 8'd192});
    push_pixel(pixel_t'{8'd128, 8'd128, 8'd128});
    pix_if.valid <= 1'b0;
    wait_idle();

    // zero width and zero height both act as one: every pixel ends a frame
    load_frame_size(1'b1, 16'd0, 1'b1, 16'd0);
    push_pixel(pixel_t'{8'd200, 8'd100, 8'd50});
    push_pixel(pixel_t'{8'd17,  8'd250, 8'd130});
    push_pixel(pixel_t'{8'd255, 8'd255, 8'd0});
    pix_if.valid <= 1'b0;
    wait_idle();

    // 3x2 frame: carry clamps above 255, and a last row
    load_frame_size(1'b1, 16'd3, 1'b1, 16'd2);
    push_pixel(pixel_t'{8'd31,  8'd31,  8'd63});
    push_pixel(pixel_t'{8'd255, 8'd255, 8'd255});
    push_pixel(pixel_t'{8'd250, 8'd250, 8'd250});
    push_pixel(pixel_t'{8'd0,   8'd0,   8'd0});
    push_pixel(pixel_t'{8'd3,   8'd3,   8'd3});
    push_pixel(pixel_t'{8'd255, 8'd255, 8'd255});
    pix_if.valid <= 1'b0;
    wait_idle();

    // random phases; each ends at a random point, often mid-frame
    phase_no    = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      set_w = 1'b1;
      set_h = 1'b1;
      case (phase_no)
        0: begin
          // width above the line size acts as the line size: one full row of it and part of the next
          w = 2047;
          h = 2;
          count = MAX_COLS + 6;
        end
        1: begin
          w = MAX_COLS;
          h = 65535;
          count = 40;
        end
        2: begin
          w = 0;
          h = $urandom_range(1, 4);
          count = $urandom_range(3, 12);
        end
        3: begin
          w = $urandom_range(1, 6);
          h = 0;
          count = $urandom_range(w, 3 * w + 2);
        end
        default: begin
          w = $urandom_range(1, 9);
          h = $urandom_range(1, 5);
          count = $urandom_range(1, 2 * w * h + w);
          if (count > 60) count = 60;
          // sometimes leave a register alone; with neither written the frame goes on
          set_w = ($urandom_range(0, 4) != 0);
          set_h = ($urandom_range(0, 4) != 0);
        end
      endcase
      w_word = CFG_DATA_W'(w);
      // bits above the width register are dropped
      if (phase_no > 3 && $urandom_range(0, 3) == 0)
        w_word = w_word | (CFG_DATA_W'($urandom_range(1, 31)) << WIDTH_REG_W);
      load_frame_size(set_w, w_word, set_h, CFG_DATA_W'(h));
      choose_pacing();
      send_pixels(count);
      wait_idle();
      random_sent += count;
      phase_no++;
    end

    // drain with the receiver always ready so a stray index would show up
    rx_mode <= RX_ALWAYS;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d pixels over %0d phases, %0d frames completed, %0d register writes",
             sb.pixels_seen, phase_no, sb.frames_ended, sb.reg_writes);
    $display("%0d mismatches, %0d indices still outstanding",
             sb.mismatches, sb.pending_indices.size());
    if (sb.mismatches == 0 && sb.pending_indices.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
